// ----- rtl/mvfd_pkg.sv -----
// ---------------------------------------------------------------------------
// mvfd_pkg: shared types and constants of the vop frame delimiter
// start code values, register map, result kinds and the item structs
// ---------------------------------------------------------------------------
`default_nettype none

package mvfd_pkg;

  // start code detection
  localparam logic [23:0] PrefixWord   = 24'h000001;
  localparam logic [23:0] WindowReset  = 24'hFFFFFF;
  localparam logic [7:0]  SeqCode      = 8'hB0;
  localparam logic [7:0]  GroupCode    = 8'hB3;
  localparam logic [7:0]  VopCode      = 8'hB6;

  // frame byte counts
  localparam int unsigned CountW        = 21;
  localparam logic [CountW-1:0] PrefixLen     = 21'd4;
  localparam logic [CountW-1:0] MinInnerCount = 21'd8;
  localparam logic [CountW-1:0] LimitMin      = 21'd8;
  localparam logic [CountW-1:0] LimitMax      = 21'd1048576;
  localparam logic [CountW-1:0] LimitReset    = 21'd65536;

  // register map: one register, index taken from paddr[2]
  localparam int unsigned AddrW = 3;
  localparam logic RegFrameByteLimit = 1'b0;

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = 2;
  localparam int unsigned FillW     = 3;

  // result kinds
  localparam logic [1:0] KindSeq     = 2'd0;
  localparam logic [1:0] KindVop     = 2'd1;
  localparam logic [1:0] KindUnsynced = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEQ  = 2'd1,
    MODE_VOP  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } mvfd_in_t;

  typedef struct packed {
    logic [CountW-1:0] frame_length;
    logic [1:0]        frame_kind;
    logic              hit_limit;
    logic              stream_end;
  } mvfd_out_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    mvfd_out_t  first;
    mvfd_out_t  second;
  } mvfd_push_t;

  function automatic logic [1:0] kind_of(mode_e mode);
    logic [1:0] kind;
    case (mode)
      MODE_SEQ: kind = KindSeq;
      MODE_VOP: kind = KindVop;
      default:  kind = KindUnsynced;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mvfd_cfg.sv -----
// ---------------------------------------------------------------------------
// mvfd_cfg: configuration register block
// apb-style write and read of the frame byte limit, clamped for the core
// ---------------------------------------------------------------------------
`default_nettype none

module mvfd_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mvfd_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [mvfd_pkg::CountW-1:0] limit_o
);
  import mvfd_pkg::*;

  logic [CountW-1:0] limit_q, limit_d;
  logic              wr_en;

  // write decode
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegFrameByteLimit);

  always_comb begin
    limit_d = limit_q;
    if (wr_en) begin
      limit_d = pwdata[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else begin
      limit_q <= limit_d;
    end
  end

  // read back
  assign prdata = (paddr[2] == RegFrameByteLimit) ? {{(32-CountW){1'b0}}, limit_q} : 32'd0;

  // clamp to the legal range
  always_comb begin
    if (limit_q < LimitMin) begin
      limit_o = LimitMin;
    end else if (limit_q > LimitMax) begin
      limit_o = LimitMax;
    end else begin
      limit_o = limit_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mvfd_core.sv -----
// ---------------------------------------------------------------------------
// mvfd_core: start code scanner and frame state
// consumes one byte per transfer and produces up to two frame results
// ---------------------------------------------------------------------------
`default_nettype none

module mvfd_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire mvfd_pkg::mvfd_in_t          item_i,
  input  wire logic [mvfd_pkg::CountW-1:0] limit_i,
  output mvfd_pkg::mvfd_push_t             push_o
);
  import mvfd_pkg::*;

  logic [23:0]       window_q, window_d;
  logic [CountW-1:0] count_q, count_d;
  mode_e             mode_q, mode_d;
  logic              group_q, group_d;

  logic [CountW-1:0] count_inc, close_len, cnt_a, cnt_b;
  logic              code_hit, is_seq, is_grp, is_vop;
  logic              close, group_step, emit_close, hit, end_emit;
  mode_e             mode_a, mode_b;
  logic              group_a, group_b;
  logic [23:0]       window_a, window_b;
  mvfd_out_t         res_close, res_lim, res_end;

  // start code recognition
  assign count_inc = count_q + 21'd1;
  assign code_hit  = (window_q == PrefixWord);
  assign is_seq    = code_hit && (item_i.data_byte == SeqCode);
  assign is_grp    = code_hit && (item_i.data_byte == GroupCode);
  assign is_vop    = code_hit && (item_i.data_byte == VopCode);

  // close decision per frame mode
  always_comb begin
    close      = 1'b0;
    group_step = group_q;
    case (mode_q)
      MODE_SEQ: begin
        if (count_inc >= MinInnerCount) begin
          if (is_grp) begin
            group_step = 1'b1;
          end else if (is_seq) begin
            close = 1'b1;
          end else if (is_vop) begin
            if (group_q) begin
              group_step = 1'b0;
            end else begin
              close = 1'b1;
            end
          end
        end
      end
      MODE_VOP: begin
        close = (count_inc >= MinInnerCount) && (is_seq || is_vop);
      end
      default: begin
        close = (count_inc >= PrefixLen) && (is_seq || is_vop);
      end
    endcase
  end

  // state after the start code step
  assign close_len  = count_inc - PrefixLen;
  assign emit_close = close && ((close_len != '0) || (mode_q == MODE_SEQ) ||
                                (mode_q == MODE_VOP));
  assign mode_a     = close ? (is_seq ? MODE_SEQ : MODE_VOP) : mode_q;
  assign cnt_a      = close ? PrefixLen : count_inc;
  assign group_a    = close ? 1'b0 : group_step;
  assign window_a   = {window_q[15:0], item_i.data_byte};

  // byte limit close
  assign hit      = (cnt_a >= limit_i);
  assign cnt_b    = hit ? '0 : cnt_a;
  assign mode_b   = hit ? MODE_IDLE : mode_a;
  assign group_b  = hit ? 1'b0 : group_a;
  assign window_b = hit ? WindowReset : window_a;

  // result records
  assign end_emit = item_i.stream_last && (cnt_b != '0);

  always_comb begin
    res_close.frame_length = close_len;
    res_close.frame_kind   = kind_of(mode_q);
    res_close.hit_limit    = 1'b0;
    res_close.stream_end   = 1'b0;

    res_lim.frame_length   = cnt_a;
    res_lim.frame_kind     = kind_of(mode_a);
    res_lim.hit_limit      = 1'b1;
    res_lim.stream_end     = item_i.stream_last;

    res_end.frame_length   = cnt_b;
    res_end.frame_kind     = kind_of(mode_b);
    res_end.hit_limit      = 1'b0;
    res_end.stream_end     = 1'b1;
  end

  // pack results in order
  always_comb begin
    push_o.second = res_end;
    if (emit_close || hit) begin
      push_o.first = emit_close ? res_close : res_lim;
      push_o.cnt   = end_emit ? 2'd2 : 2'd1;
    end else begin
      push_o.first = res_end;
      push_o.cnt   = end_emit ? 2'd1 : 2'd0;
    end
    if (!accept_i) begin
      push_o.cnt = 2'd0;
    end
  end

  // next state, cleared after the final byte
  always_comb begin
    window_d = window_q;
    count_d  = count_q;
    mode_d   = mode_q;
    group_d  = group_q;
    if (accept_i) begin
      if (item_i.stream_last) begin
        window_d = WindowReset;
        count_d  = '0;
        mode_d   = MODE_IDLE;
        group_d  = 1'b0;
      end else begin
        window_d = window_b;
        count_d  = cnt_b;
        mode_d   = mode_b;
        group_d  = group_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
      count_q  <= '0;
      mode_q   <= MODE_IDLE;
      group_q  <= 1'b0;
    end else begin
      window_q <= window_d;
      count_q  <= count_d;
      mode_q   <= mode_d;
      group_q  <= group_d;
    end
  end

  // group flag only lives inside a sequence-led frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_q |-> (mode_q == MODE_SEQ))
    else $error("group flag set outside a sequence-led frame");

  // final byte leaves the scanner in its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.stream_last) |=>
      (count_q == '0) && (mode_q == MODE_IDLE) && (window_q == WindowReset))
    else $error("state not cleared after final byte");

  // a limit close never reports fewer bytes than the smallest limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((push_o.cnt != 2'd0) && push_o.first.hit_limit) |->
      (push_o.first.frame_length >= LimitMin))
    else $error("limit close below minimum frame size");

  // a synced frame is never shorter than its opening code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> (count_q >= PrefixLen))
    else $error("synced frame shorter than its start code");

endmodule

`default_nettype wire

// ----- rtl/mvfd_rfifo.sv -----
// ---------------------------------------------------------------------------
// mvfd_rfifo: result queue
// takes up to two results per cycle and hands out one per transfer
// ---------------------------------------------------------------------------
`default_nettype none

module mvfd_rfifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mvfd_pkg::mvfd_push_t push_i,
  output logic                      space_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output mvfd_pkg::mvfd_out_t       out_data_o
);
  import mvfd_pkg::*;

  mvfd_out_t        mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_p1;
  logic [FillW-1:0] fill_q, fill_d;
  logic             pop;

  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of two results from one byte
  assign space_o     = (fill_q <= FillW'(FifoDepth - 2));
  assign wr_ptr_p1   = wr_ptr_q + 1'b1;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + FillW'(push_i.cnt) - FillW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.second;
    end
  end

  // never more entries than storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(FifoDepth))
    else $error("result queue overflow");

  // pointers and fill agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != FillW'(FifoDepth)) |-> (fill_q[PtrW-1:0] == PtrW'(wr_ptr_q - rd_ptr_q)))
    else $error("result queue pointers out of step with fill");

  // results only arrive while room was advertised
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> $past(space_o) || (fill_q <= FillW'(FifoDepth - 2)))
    else $error("results pushed without room");

endmodule

`default_nettype wire

// ----- rtl/mpeg4_vop_frame_delimiter_top.sv -----
// ---------------------------------------------------------------------------
// mpeg4_vop_frame_delimiter_top: mpeg-4 start code frame delimiter
// cuts a byte stream into frames at 00 00 01 xx start codes
// ---------------------------------------------------------------------------
// One stream byte is taken per transfer, one per cycle at full rate: the
// scanner registers its new window, count and mode for each accepted byte and
// pushes zero, one or two results into a four-entry result queue. The input
// stays ready while the queue has room for two results, so the rate drops
// below one byte per cycle only when the output side stalls and the queue
// fills. A result is queued with the byte that closed its frame.
// The frame byte limit at address 0 is clamped to 8..1048576 and is to be
// written only while the block is idle.
`default_nettype none

module mpeg4_vop_frame_delimiter_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire mvfd_pkg::mvfd_in_t         in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output mvfd_pkg::mvfd_out_t             out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mvfd_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import mvfd_pkg::*;

  logic [CountW-1:0] limit;
  logic              accept;
  logic              space;
  mvfd_push_t        push;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  // configuration register
  mvfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // start code scanner
  mvfd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .limit_i  (limit),
    .push_o   (push)
  );

  // result queue
  mvfd_rfifo u_rfifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/frame_cut_pkg.sv -----
// ---------------------------------------------------------------------------
// frame_cut_pkg: expected-frame predictor for the vop frame delimiter bench
// tracks the start code scanner state per accepted byte, queues the frames
// it expects and checks each frame the block delivers
// ---------------------------------------------------------------------------
`default_nettype none

package frame_cut_pkg;

  import mvfd_pkg::*;

  localparam int unsigned MaxShown = 10;

  class frame_cut_predictor;

    logic [CountW-1:0] byte_limit;
    logic [23:0]       recent_bytes;
    logic [CountW-1:0] open_count;
    mode_e             open_mode;
    logic              group_open;
    mvfd_out_t         frames_due[$];
    int unsigned       errors;

    // register and scanner state after reset
    function void power_on();
      byte_limit = LimitReset;
      errors     = 0;
      restart();
    endfunction

    // scanner back to its reset state, the register is kept
    function void restart();
      recent_bytes = WindowReset;
      open_count   = '0;
      open_mode    = MODE_IDLE;
      group_open   = 1'b0;
    endfunction

    function void set_limit(logic [CountW-1:0] value);
      byte_limit = value;
    endfunction

    function logic [1:0] kind_for(mode_e m);
      logic [1:0] k;
      case (m)
        MODE_SEQ: k = KindSeq;
        MODE_VOP: k = KindVop;
        default:  k = KindUnsynced;
      endcase
      return k;
    endfunction

    function void emit(logic [CountW-1:0] len, logic [1:0] kind, logic hit, logic fin);
      mvfd_out_t f;
      f.frame_length = len;
      f.frame_kind   = kind;
      f.hit_limit    = hit;
      f.stream_end   = fin;
      frames_due.push_back(f);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MaxShown) $display("[%0t] %s", $time, msg);
    endfunction

    // one accepted stream byte: update the scanner, queue closed frames
    function void take_byte(mvfd_in_t item);
      logic [7:0]        b;
      logic [CountW-1:0] cnt;
      logic [CountW-1:0] clamp;
      logic              at_code;
      logic              cut;
      int                made;
      mvfd_out_t         tail;
      b       = item.data_byte;
      cnt     = open_count + 1'b1;
      at_code = (recent_bytes == PrefixWord);
      cut     = 1'b0;
      made    = frames_due.size();

      // start code decision for the open frame
      case (open_mode)
        MODE_SEQ: begin
          if (at_code && cnt >= MinInnerCount) begin
            if (b == GroupCode) begin
              group_open = 1'b1;
            end else if (b == SeqCode) begin
              cut = 1'b1;
            end else if (b == VopCode) begin
              if (group_open) group_open = 1'b0;
              else cut = 1'b1;
            end
          end
        end
        MODE_VOP: begin
          cut = at_code && cnt >= MinInnerCount && (b == SeqCode || b == VopCode);
        end
        default: begin
          cut = at_code && cnt >= PrefixLen && (b == SeqCode || b == VopCode);
        end
      endcase

      // closing code becomes the head of the next frame
      if (cut) begin
        if (cnt != PrefixLen || open_mode != MODE_IDLE)
          emit(cnt - PrefixLen, kind_for(open_mode), 1'b0, 1'b0);
        open_count = PrefixLen;
        open_mode  = (b == SeqCode) ? MODE_SEQ : MODE_VOP;
        group_open = 1'b0;
      end else begin
        open_count = cnt;
      end
      recent_bytes = {recent_bytes[15:0], b};

      // byte limit, clamped to its legal range
      clamp = byte_limit;
      if (clamp < LimitMin) clamp = LimitMin;
      if (clamp > LimitMax) clamp = LimitMax;
      if (open_count >= clamp) begin
        emit(open_count, kind_for(open_mode), 1'b1, 1'b0);
        restart();
      end

      // end of stream flushes the open frame or tags the last frame
      if (item.stream_last) begin
        if (open_count != '0) begin
          emit(open_count, kind_for(open_mode), 1'b0, 1'b1);
        end else if (frames_due.size() > made) begin
          tail = frames_due.pop_back();
          tail.stream_end = 1'b1;
          frames_due.push_back(tail);
        end
        restart();
      end
    endfunction

    // one delivered frame against the oldest expected one
    function void check_frame(mvfd_out_t got);
      mvfd_out_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("frame with none expected: len %0d kind %0d limit %0b end %0b",
                         got.frame_length, got.frame_kind, got.hit_limit, got.stream_end));
      end else begin
        want = frames_due.pop_front();
        if (got.frame_length !== want.frame_length || got.frame_kind !== want.frame_kind ||
            got.hit_limit !== want.hit_limit || got.stream_end !== want.stream_end)
          report($sformatf({"frame mismatch: expected len %0d kind %0d limit %0b end %0b,",
                            " got len %0d kind %0d limit %0b end %0b"},
                           want.frame_length, want.frame_kind, want.hit_limit,
                           want.stream_end, got.frame_length, got.frame_kind,
                           got.hit_limit, got.stream_end));
      end
    endfunction

  endclass

endpackage

`default_nettype wire

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: vop frame delimiter block test
// drives byte streams with start codes and noise through the valid/ready
// input, writes limit changes through the register port, stalls the frame
// output at random and compares every delivered frame with the predicted one
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import mvfd_pkg::*;
  import frame_cut_pkg::*;

  localparam int unsigned StreamBytes  = 600;
  localparam int unsigned SettleCycles = 8;
  localparam logic [AddrW-1:0] LimitAddr = {RegFrameByteLimit, 2'b00};

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready_o;
  mvfd_in_t             in_data   = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  mvfd_out_t            out_data_o;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [AddrW-1:0]     paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;

  frame_cut_predictor   splitter;
  logic [7:0]           plan_bytes[$];
  int unsigned          bytes_sent = 0;
  int unsigned          src_idle_level  = 2;
  int unsigned          sink_idle_level = 2;

  mpeg4_vop_frame_delimiter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  // idle cycles before one transfer: none, occasional or full range
  function automatic int unsigned draw_gap(int unsigned level);
    int unsigned g;
    case (level)
      0:       g = 0;
      1:       g = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
      default: g = $urandom_range(0, 15);
    endcase
    return g;
  endfunction

  // zero-heavy random data byte
  function automatic logic [7:0] rand_data();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_code(logic [7:0] c);
    plan_bytes.push_back(8'h00);
    plan_bytes.push_back(8'h00);
    plan_bytes.push_back(8'h01);
    plan_bytes.push_back(c);
  endfunction

  function automatic void add_payload(int unsigned n);
    repeat (n) plan_bytes.push_back(rand_data());
  endfunction

  // mostly short frame bodies, sometimes longer
  function automatic int unsigned body_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
  endfunction

  function automatic logic [CountW-1:0] pick_limit();
    logic [CountW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = CountW'($urandom_range(0, 7));
      1:       v = LimitMax;
      2:       v = CountW'($urandom_range(1048577, 2097151));
      3:       v = LimitReset;
      4, 5:    v = CountW'($urandom_range(41, 400));
      default: v = CountW'($urandom_range(8, 40));
    endcase
    return v;
  endfunction

  // one random stream: well-formed frames, noise, or broken codes
  function automatic void plan_stream();
    int unsigned pick;
    int unsigned b;
    pick = $urandom_range(0, 7);
    if (pick < 6) begin
      if ($urandom_range(0, 3) == 0) add_payload($urandom_range(1, 4));
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 2))
          0: begin
            add_code(VopCode);
            add_payload(body_len());
            if ($urandom_range(0, 5) == 0) begin
              add_code(GroupCode);
              add_payload(body_len());
            end
          end
          1: begin
            add_code(SeqCode);
            add_payload(body_len());
            add_code(GroupCode);
            add_payload(body_len());
            if ($urandom_range(0, 4) != 0) begin
              add_code(VopCode);
              add_payload(body_len());
            end
          end
          default: begin
            add_code(SeqCode);
            add_payload(body_len());
          end
        endcase
      end
    end else if (pick == 6) begin
      repeat ($urandom_range(4, 30)) begin
        if ($urandom_range(0, 3) == 0) add_code(8'($urandom_range(0, 255)));
        else plan_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      add_code(($urandom_range(0, 1) == 0) ? SeqCode : VopCode);
      repeat ($urandom_range(1, 6)) begin
        b = $urandom_range(0, 3);
        plan_bytes.push_back(8'h00);
        if (b != 0) plan_bytes.push_back((b == 1) ? 8'h00 : 8'h01);
        plan_bytes.push_back((b == 3) ? GroupCode : (b == 2 ? SeqCode : VopCode));
        add_payload($urandom_range(0, 5));
      end
    end
  endfunction

  // one byte transfer; returns at the falling edge after acceptance
  task automatic push_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = draw_gap(src_idle_level);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // send the planned bytes, marking the final one when asked
  task automatic send_plan(logic with_last);
    for (int i = 0; i < plan_bytes.size(); i++) begin
      push_byte(plan_bytes[i], with_last && (i == plan_bytes.size() - 1));
      bytes_sent++;
    end
    plan_bytes.delete();
  endtask

  // stop the input and let every expected frame come out
  task automatic settle();
    in_valid <= 1'b0;
    while (splitter.frames_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // register write: setup then access cycle
  task automatic write_limit(logic [CountW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= {{(32 - CountW){1'b0}}, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    splitter.set_limit(value);
  endtask

  // frame output side: random stall before each transfer
  initial begin : sink_side
    int unsigned stall;
    @(negedge clk_i);
    forever begin
      stall = draw_gap(sink_idle_level);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
      @(negedge clk_i);
    end
  end

  // check delivered frames, then predict from the accepted byte
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) splitter.check_frame(out_data_o);
      if (in_valid && in_ready_o) splitter.take_byte(in_data);
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned random_start;
    splitter = new;
    splitter.power_on();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // header first, vop frame, sequence frame through group and vop,
    // group code inside a vop frame, closing code as the final byte
    src_idle_level  = 0;
    sink_idle_level = 1;
    add_code(VopCode);
    plan_bytes.push_back(8'h5A);
    add_code(SeqCode);
    add_code(GroupCode);
    add_code(VopCode);
    add_code(VopCode);
    add_code(GroupCode);
    add_code(SeqCode);
    send_plan(1'b1);

    // single byte stream
    plan_bytes.push_back(8'hFF);
    send_plan(1'b1);

    // limit below range acts as the minimum
    settle();
    write_limit('0);
    repeat (8) plan_bytes.push_back(8'hA5);
    plan_bytes.push_back(8'h00);
    send_plan(1'b1);

    // limit lowered under an open frame, closed on the final byte
    settle();
    write_limit(LimitReset);
    add_code(VopCode);
    add_payload(6);
    send_plan(1'b0);
    settle();
    write_limit(LimitMin);
    plan_bytes.push_back(8'hFF);
    send_plan(1'b1);

    // random streams with limit changes between them
    settle();
    write_limit(21'h1FFFFF);
    random_start = bytes_sent;
    while (bytes_sent - random_start < StreamBytes) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        write_limit(pick_limit());
      end
      if ($urandom_range(0, 4) == 0) begin
        src_idle_level  = $urandom_range(0, 2);
        sink_idle_level = $urandom_range(0, 2);
      end
      plan_stream();
      send_plan($urandom_range(0, 3) != 0);
    end

    // drain and finish
    settle();
    repeat (20) @(negedge clk_i);
    if (splitter.frames_due.size() != 0)
      splitter.report($sformatf("%0d expected frames never delivered",
                                splitter.frames_due.size()));
    if (splitter.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/mvfd_pkg.sv
rtl/mvfd_cfg.sv
rtl/mvfd_core.sv
rtl/mvfd_rfifo.sv
rtl/mpeg4_vop_frame_delimiter_top.sv
tb/frame_cut_pkg.sv
tb/testbench.sv
